// File: hdl/cixs_pkg.sv
// Shared widths, register map and status types for the chunked interleave XOR scrambler.
package cixs_pkg;

   // Offset width and chunk length width
   localparam int SIZE_BITS  = 24;
   localparam int CHUNK_BITS = 17;

   // Data size and region length carry one extra bit so that 2^SIZE_BITS fits
   localparam int DS_W = SIZE_BITS + 1;
   localparam logic [DS_W-1:0] DS_LIMIT = DS_W'(1) << SIZE_BITS;

   // Interleave offset math needs two bits above the chunk length
   localparam int REL_W = CHUNK_BITS + 2;

   // Result beat: out_offset, out_byte, padded to whole bytes
   localparam int RSP_DATA_W = ((SIZE_BITS + 8 + 7) / 8) * 8;

   // Remainder unit: one dividend bit per cycle, then a final step to form the region length
   localparam int DIV_START = DS_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_START + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_MODE       = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_DATA_SIZE  = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_KEY_START  = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_KEY_STEP   = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_CHUNK_SIZE = REG_IDX_W'(4);
   localparam logic [REG_IDX_W-1:0] REG_MAX_BYTES  = REG_IDX_W'(5);

   localparam logic MODE_DECRYPT = 1'b0;
   localparam logic MODE_ENCRYPT = 1'b1;

   // Region unit status toward the stream datapath
   typedef struct packed {
      logic            busy;
      logic [DS_W-1:0] enc_len;
   } region_status_type;

endpackage

// File: hdl/cixs_region.sv
// Encrypted region length unit: serial remainder of data size by chunk size.
module cixs_region (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [cixs_pkg::DS_W-1:0]            data_size,
   input  logic [cixs_pkg::CHUNK_BITS-1:0]      chunk_size,
   output cixs_pkg::region_status_type          status
);

   logic [cixs_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [cixs_pkg::CHUNK_BITS-1:0] rem_ff, rem_in;
   logic [cixs_pkg::DS_W-1:0]       enc_ff, enc_in;

   logic [cixs_pkg::DIV_CNT_W-1:0]  bit_sel;
   logic [cixs_pkg::CHUNK_BITS:0]   rem_sh;
   logic [cixs_pkg::CHUNK_BITS:0]   rem_dif;
   logic [cixs_pkg::CHUNK_BITS-1:0] quarter;
   logic [cixs_pkg::CHUNK_BITS-1:0] rem_skip;
   logic [cixs_pkg::DS_W-1:0]       skip;

   always_comb begin
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      enc_in   = enc_ff;
      bit_sel  = cnt_ff - cixs_pkg::DIV_CNT_W'(2);
      rem_sh   = {rem_ff, data_size[bit_sel]};
      rem_dif  = rem_sh - {1'b0, chunk_size};
      quarter  = chunk_size >> 2;
      rem_skip = (rem_ff < quarter) ? rem_ff : '0;
      skip     = cixs_pkg::DS_W'(rem_skip) + cixs_pkg::DS_W'(data_size[0]);
      if (start) begin
         cnt_in = cixs_pkg::DIV_CNT_W'(cixs_pkg::DIV_START);
         rem_in = '0;
      end else if (cnt_ff > cixs_pkg::DIV_CNT_W'(1)) begin
         // restoring step: shift in the next dividend bit, subtract if it fits
         rem_in = (rem_sh >= {1'b0, chunk_size}) ? rem_dif[cixs_pkg::CHUNK_BITS-1:0]
                                                 : rem_sh[cixs_pkg::CHUNK_BITS-1:0];
         cnt_in = cnt_ff - cixs_pkg::DIV_CNT_W'(1);
      end else if (cnt_ff == cixs_pkg::DIV_CNT_W'(1)) begin
         // drop a short tail and a final odd byte
         enc_in = (data_size > skip) ? (data_size - skip) : '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= cixs_pkg::DIV_CNT_W'(cixs_pkg::DIV_START);
         rem_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
      end
      enc_ff <= enc_in;
   end

   assign status.busy    = (cnt_ff != '0);
   assign status.enc_len = enc_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> status.busy)
      else $error("region unit not busy after restart");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == cixs_pkg::DIV_CNT_W'(1)) && !start |=> !status.busy)
      else $error("region unit did not finish");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> status.enc_len <= data_size)
      else $error("region longer than data size");

endmodule

// File: hdl/chunked_interleave_xor_scrambler.sv
// Top level: stream datapath, configuration registers and region unit of the scrambler.
//
// One byte enters per beat and one result beat leaves for it, carrying the file offset where
// the byte belongs, the byte itself and tlast on the final byte of the file. The datapath
// sustains one byte per clock cycle while the result side is ready and the region unit is
// idle; an accepted byte passes through the input register and then the result register,
// around a single pass of chunk bookkeeping, an 8x8 key product and the XOR. After reset
// and after every write of data_size or chunk_size, a serial remainder unit takes one bit of
// data_size per cycle, then forms the region length; req_tready stays low meanwhile.
// The region length is latched on the first byte of each file and chunk_size and max_bytes
// are read as each chunk starts; mode and key_step act on every byte.
module chunked_interleave_xor_scrambler (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cixs_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [23:0] out_offset, [31:24] out_byte
   output logic                              rsp_tlast,   // file_done
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cixs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cixs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cixs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // ---------------- configuration registers ----------------
   logic                              mode_ff, mode_in;
   logic [cixs_pkg::DS_W-1:0]         data_size_ff, data_size_in;
   logic [7:0]                        key_start_ff, key_start_in;
   logic [7:0]                        key_step_ff, key_step_in;
   logic [cixs_pkg::CHUNK_BITS-1:0]   chunk_size_ff, chunk_size_in;
   logic [cixs_pkg::DS_W-1:0]         max_bytes_ff, max_bytes_in;

   logic                              cfg_wr;
   logic [cixs_pkg::REG_IDX_W-1:0]    reg_sel;
   logic                              region_start;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[cixs_pkg::CSR_ADDR_W-1:2];
   assign region_start = cfg_wr && ((reg_sel == cixs_pkg::REG_DATA_SIZE) ||
                                    (reg_sel == cixs_pkg::REG_CHUNK_SIZE));

   always_comb begin
      mode_in       = mode_ff;
      data_size_in  = data_size_ff;
      key_start_in  = key_start_ff;
      key_step_in   = key_step_ff;
      chunk_size_in = chunk_size_ff;
      max_bytes_in  = max_bytes_ff;
      if (cfg_wr) begin
         case (reg_sel)
            cixs_pkg::REG_MODE:       mode_in       = csr_pwdata[0];
            cixs_pkg::REG_DATA_SIZE:  data_size_in  = csr_pwdata[cixs_pkg::DS_W-1:0];
            cixs_pkg::REG_KEY_START:  key_start_in  = csr_pwdata[7:0];
            cixs_pkg::REG_KEY_STEP:   key_step_in   = csr_pwdata[7:0];
            cixs_pkg::REG_CHUNK_SIZE: chunk_size_in = csr_pwdata[cixs_pkg::CHUNK_BITS-1:0];
            cixs_pkg::REG_MAX_BYTES:  max_bytes_in  = csr_pwdata[cixs_pkg::DS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= cixs_pkg::MODE_DECRYPT;
         data_size_ff  <= cixs_pkg::DS_W'(1);
         key_start_ff  <= '0;
         key_step_ff   <= '0;
         chunk_size_ff <= cixs_pkg::CHUNK_BITS'(1);
         max_bytes_ff  <= cixs_pkg::DS_LIMIT;
      end else begin
         mode_ff       <= mode_in;
         data_size_ff  <= data_size_in;
         key_start_ff  <= key_start_in;
         key_step_ff   <= key_step_in;
         chunk_size_ff <= chunk_size_in;
         max_bytes_ff  <= max_bytes_in;
      end
   end

   always_comb begin
      case (reg_sel)
         cixs_pkg::REG_MODE:       csr_prdata = cixs_pkg::CSR_DATA_W'(mode_ff);
         cixs_pkg::REG_DATA_SIZE:  csr_prdata = cixs_pkg::CSR_DATA_W'(data_size_ff);
         cixs_pkg::REG_KEY_START:  csr_prdata = cixs_pkg::CSR_DATA_W'(key_start_ff);
         cixs_pkg::REG_KEY_STEP:   csr_prdata = cixs_pkg::CSR_DATA_W'(key_step_ff);
         cixs_pkg::REG_CHUNK_SIZE: csr_prdata = cixs_pkg::CSR_DATA_W'(chunk_size_ff);
         cixs_pkg::REG_MAX_BYTES:  csr_prdata = cixs_pkg::CSR_DATA_W'(max_bytes_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // clamp out-of-range sizes
   logic [cixs_pkg::DS_W-1:0]       ds_eff;
   logic [cixs_pkg::CHUNK_BITS-1:0] cs_eff;

   always_comb begin
      if (data_size_ff == '0)
         ds_eff = cixs_pkg::DS_W'(1);
      else if (data_size_ff > cixs_pkg::DS_LIMIT)
         ds_eff = cixs_pkg::DS_LIMIT;
      else
         ds_eff = data_size_ff;
      cs_eff = (chunk_size_ff == '0) ? cixs_pkg::CHUNK_BITS'(1) : chunk_size_ff;
   end

   cixs_pkg::region_status_type region;

   cixs_region u_region (
      .clock      (clock),
      .reset      (reset),
      .start      (region_start),
      .data_size  (ds_eff),
      .chunk_size (cs_eff),
      .status     (region)
   );

   // ---------------- stream pipeline ----------------
   logic                              in_valid_ff, in_valid_in;
   logic [7:0]                        in_byte_ff, in_byte_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cixs_pkg::SIZE_BITS-1:0]    rsp_offset_ff, rsp_offset_in;
   logic [7:0]                        rsp_byte_ff, rsp_byte_in;
   logic                              rsp_last_ff, rsp_last_in;

   // per-file and per-chunk state
   logic [cixs_pkg::SIZE_BITS-1:0]    pos_ff, pos_in;
   logic [cixs_pkg::SIZE_BITS-1:0]    start_ff, start_in;
   logic [cixs_pkg::CHUNK_BITS-1:0]   len_ff, len_in;
   logic [cixs_pkg::CHUNK_BITS-1:0]   q_ff, q_in;
   logic                              active_ff, active_in;
   logic [7:0]                        base_ff, base_in;
   logic [cixs_pkg::DS_W-1:0]         enc_ff, enc_in;

   logic adv;
   logic req_fire;

   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (!in_valid_ff || adv) && !region.busy;
   assign req_fire   = req_tvalid && req_tready;

   // byte processing
   logic                              file0;
   logic                              cur_active;
   logic [cixs_pkg::CHUNK_BITS-1:0]   cur_len;
   logic [7:0]                        cur_base;
   logic [cixs_pkg::DS_W-1:0]         cur_enc;
   logic [cixs_pkg::SIZE_BITS-1:0]    cur_start;
   logic [cixs_pkg::DS_W-1:0]         pos_w;
   logic                              start_new;
   logic [cixs_pkg::DS_W-1:0]         left;
   logic [cixs_pkg::CHUNK_BITS-1:0]   new_len;
   logic [15:0]                       adv_prod;
   logic [7:0]                        base_new;
   logic [cixs_pkg::CHUNK_BITS-1:0]   len;
   logic [cixs_pkg::CHUNK_BITS-1:0]   q;
   logic [7:0]                        base;
   logic [cixs_pkg::SIZE_BITS-1:0]    cstart;
   logic                              in_chunk;
   logic [cixs_pkg::CHUNK_BITS:0]     len_p1;
   logic [cixs_pkg::CHUNK_BITS-1:0]   half;
   logic [cixs_pkg::REL_W-1:0]        len_w, q_w, half_w, dec_rel_w;
   logic [cixs_pkg::CHUNK_BITS-1:0]   tail_dist;
   logic [cixs_pkg::CHUNK_BITS-1:0]   enc_idx;
   logic [cixs_pkg::CHUNK_BITS-1:0]   idx;
   logic [cixs_pkg::CHUNK_BITS-1:0]   rel;
   logic [15:0]                       key_prod;
   logic [7:0]                        key;
   logic [cixs_pkg::DS_W-1:0]         pos_p1;
   logic                              done;

   always_comb begin
      file0      = (pos_ff == '0);
      // first byte of a file: latch the region and clear the chunk
      cur_active = file0 ? 1'b0 : active_ff;
      cur_len    = file0 ? '0 : len_ff;
      cur_base   = file0 ? key_start_ff : base_ff;
      cur_enc    = file0 ? region.enc_len : enc_ff;
      cur_start  = file0 ? '0 : start_ff;

      pos_w     = {1'b0, pos_ff};
      start_new = !cur_active && (pos_w < cur_enc) && (pos_w < max_bytes_ff);
      left      = cur_enc - pos_w;
      new_len   = (cixs_pkg::DS_W'(cs_eff) < left) ? cs_eff
                                                   : left[cixs_pkg::CHUNK_BITS-1:0];
      adv_prod  = key_step_ff * 8'(cur_len);
      base_new  = cur_base + adv_prod[7:0];

      len      = start_new ? new_len : cur_len;
      q        = start_new ? '0 : q_ff;
      base     = start_new ? base_new : cur_base;
      cstart   = start_new ? pos_ff : cur_start;
      in_chunk = start_new || cur_active;

      // interleave: h = ceil(L/2)
      len_p1 = {1'b0, len} + (cixs_pkg::CHUNK_BITS + 1)'(1);
      half   = len_p1[cixs_pkg::CHUNK_BITS:1];
      len_w  = cixs_pkg::REL_W'(len);
      q_w    = cixs_pkg::REL_W'(q);
      half_w = cixs_pkg::REL_W'(half);
      dec_rel_w = (q < half) ? (len_w - cixs_pkg::REL_W'(1) - (q_w << 1))
                             : (len_w - cixs_pkg::REL_W'(2) - (q_w << 1) + (half_w << 1));
      tail_dist = len - cixs_pkg::CHUNK_BITS'(1) - q;
      enc_idx   = (tail_dist >> 1) + (tail_dist[0] ? half : '0);

      if (mode_ff == cixs_pkg::MODE_ENCRYPT) begin
         idx = enc_idx;
         rel = enc_idx;
      end else begin
         idx = q;
         rel = dec_rel_w[cixs_pkg::CHUNK_BITS-1:0];
      end
      key_prod = key_step_ff * 8'(idx);
      key      = base + key_prod[7:0];

      pos_p1 = pos_w + cixs_pkg::DS_W'(1);
      done   = (pos_p1 >= ds_eff);
   end

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      q_in          = q_ff;
      active_in     = active_ff;
      base_in       = base_ff;
      enc_in        = enc_ff;

      if (rsp_tready)
         rsp_valid_in = 1'b0;
      if (adv)
         in_valid_in = 1'b0;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end

      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = done;
         if (in_chunk) begin
            rsp_offset_in = cstart + cixs_pkg::SIZE_BITS'(rel);
            rsp_byte_in   = in_byte_ff ^ key;
         end else begin
            rsp_offset_in = pos_ff;
            rsp_byte_in   = in_byte_ff;
         end
         pos_in    = done ? '0 : pos_p1[cixs_pkg::SIZE_BITS-1:0];
         start_in  = cstart;
         len_in    = len;
         base_in   = base;
         enc_in    = cur_enc;
         q_in      = q + cixs_pkg::CHUNK_BITS'(1);
         active_in = in_chunk &&
                     (({1'b0, q} + (cixs_pkg::CHUNK_BITS + 1)'(1)) != {1'b0, len});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         active_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         active_ff    <= active_in;
      end
      in_byte_ff    <= in_byte_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      q_ff          <= q_in;
      base_ff       <= base_in;
      enc_ff        <= enc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = cixs_pkg::RSP_DATA_W'({rsp_byte_ff, rsp_offset_ff});
   assign rsp_tlast  = rsp_last_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !region.busy)
      else $error("beat taken while region length is being computed");

   a_file_wrap: assert property (@(posedge clock) disable iff (reset)
      adv && done |=> (pos_ff == '0) && rsp_tlast)
      else $error("position did not return to zero after last byte");

   a_chunk_index: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (q_ff < len_ff))
      else $error("chunk index beyond chunk length");

   a_rel_bound: assert property (@(posedge clock) disable iff (reset)
      adv && in_chunk |-> (rel < len))
      else $error("offset outside current chunk");

endmodule
